### src/cfd_pkg.sv
// Shared types, constants and the bytewise CRC-32 step for the frame deframer.
// No dependencies; every other file in src refers to this package by scoped names.
package cfd_pkg;

    // Default width of the payload length counter
    localparam int LEN_WIDTH_DEF = 32;

    // Configuration port geometry and register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_MAGIC   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VERSION = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEN = 2'd2;

    // Register reset values
    localparam logic [31:0] MAGIC_RESET   = 32'd0;
    localparam logic [15:0] VERSION_RESET = 16'd0;
    localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

    // Header limits and CRC-32 (reflected) constants
    localparam logic [7:0]  KIND_MAX = 8'd13;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Verdict status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_BAD_KIND    = 3'd3;
    localparam logic [2:0] ST_TOO_LONG    = 3'd4;
    localparam logic [2:0] ST_CRC_ERR     = 3'd5;

    // Input word: one stream byte plus the halt release flag
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       clear_error;
    } in_word_t;

    // Result word: a passed-through payload byte or a frame verdict
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_payload;
        logic [3:0] frame_kind;
        logic [2:0] frame_status;
        logic       frame_end;
    } out_word_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [31:0] max_len;
    } cfg_t;

    // One byte through the reflected CRC-32, eight bit steps
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### src/cfd_parser.sv
// Frame parser state machine: header checks, payload pass-through and CRC verdict.
// Depends on cfd_pkg; the result it computes is registered by the top level.
module cfd_parser #(
    parameter int LEN_WIDTH = cfd_pkg::LEN_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_accept,
    input  cfd_pkg::in_word_t   in_word,
    input  cfd_pkg::cfg_t       cfg,
    output logic                res_valid,
    output cfd_pkg::out_word_t  res
);

    typedef enum logic [6:0] {
        PH_MAGIC   = 7'b000_0001,
        PH_VERSION = 7'b000_0010,
        PH_KIND    = 7'b000_0100,
        PH_LENGTH  = 7'b000_1000,
        PH_PAYLOAD = 7'b001_0000,
        PH_CRC     = 7'b010_0000,
        PH_HALT    = 7'b100_0000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [1:0]             idx_reg, idx_next;
    logic [31:0]            shift_reg, shift_next;    // magic, then length
    logic [LEN_WIDTH-1:0]   remain_reg, remain_next;
    logic [31:0]            crc_reg, crc_next;
    logic [31:0]            rx_crc_reg, rx_crc_next;
    logic [3:0]             kind_reg, kind_next;
    logic [15:0]            ver_reg, ver_next;

    // Working copies: an unknown phase code reads as a fresh hunt
    logic                   phase_ok;
    phase_t                 cur_phase;
    logic [1:0]             cur_idx;
    logic [31:0]            cur_shift;
    logic [31:0]            cur_crc;
    logic [31:0]            cur_rx_crc;
    logic [3:0]             cur_kind;
    logic [15:0]            cur_ver;

    logic [7:0]             b;
    logic [31:0]            lane_word;
    logic [31:0]            len_full;
    logic                   len_over;
    logic [15:0]            ver_full;
    logic [31:0]            rx_full;
    logic [31:0]            crc_upd;
    logic [LEN_WIDTH-1:0]   remain_dec;

    assign b = in_word.rx_byte;

    always_comb begin
        phase_ok = (phase_reg == PH_MAGIC)   || (phase_reg == PH_VERSION) ||
                   (phase_reg == PH_KIND)    || (phase_reg == PH_LENGTH)  ||
                   (phase_reg == PH_PAYLOAD) || (phase_reg == PH_CRC)     ||
                   (phase_reg == PH_HALT);
        if (phase_ok) begin
            cur_phase  = phase_reg;
            cur_idx    = idx_reg;
            cur_shift  = shift_reg;
            cur_crc    = crc_reg;
            cur_rx_crc = rx_crc_reg;
            cur_kind   = kind_reg;
            cur_ver    = ver_reg;
        end else begin
            cur_phase  = PH_MAGIC;
            cur_idx    = 2'd0;
            cur_shift  = 32'd0;
            cur_crc    = cfd_pkg::CRC_INIT;
            cur_rx_crc = 32'd0;
            cur_kind   = 4'd0;
            cur_ver    = 16'd0;
        end
    end

    // Little-endian byte lane gathering and the checks on complete fields
    assign lane_word  = {24'd0, b} << {cur_idx, 3'b000};
    assign len_full   = cur_shift | lane_word;
    assign len_over   = ((len_full >> LEN_WIDTH) != 32'd0) || (len_full > cfg.max_len);
    assign ver_full   = cur_ver | ({8'd0, b} << {cur_idx[0], 3'b000});
    assign rx_full    = cur_rx_crc | lane_word;
    assign crc_upd    = cfd_pkg::crc32_byte(cur_crc, b);
    assign remain_dec = (remain_reg != '0) ? (remain_reg - LEN_WIDTH'(1)) : remain_reg;

    // Next state and result for the accepted word
    always_comb begin
        phase_next  = cur_phase;
        idx_next    = cur_idx;
        shift_next  = cur_shift;
        remain_next = remain_reg;
        crc_next    = cur_crc;
        rx_crc_next = cur_rx_crc;
        kind_next   = cur_kind;
        ver_next    = cur_ver;
        res_valid   = 1'b0;
        res         = '0;

        if (in_accept) begin
            unique case (cur_phase)
                PH_HALT: begin
                    if (in_word.clear_error) begin
                        phase_next  = PH_MAGIC;
                        idx_next    = 2'd0;
                        shift_next  = 32'd0;
                        ver_next    = 16'd0;
                        rx_crc_next = 32'd0;
                        crc_next    = cfd_pkg::CRC_INIT;
                        kind_next   = 4'd0;
                    end
                end
                PH_MAGIC: begin
                    shift_next = len_full;
                    idx_next   = cur_idx + 2'd1;
                    if (cur_idx == 2'd3) begin
                        idx_next = 2'd0;
                        if (len_full != cfg.magic) begin
                            phase_next       = PH_HALT;
                            res_valid        = 1'b1;
                            res.frame_status = cfd_pkg::ST_BAD_MAGIC;
                            res.frame_end    = 1'b1;
                        end else begin
                            phase_next = PH_VERSION;
                            ver_next   = 16'd0;
                        end
                    end
                end
                PH_VERSION: begin
                    ver_next = ver_full;
                    idx_next = cur_idx + 2'd1;
                    if (cur_idx[0]) begin
                        idx_next = 2'd0;
                        if (ver_full != cfg.version) begin
                            phase_next       = PH_HALT;
                            res_valid        = 1'b1;
                            res.frame_status = cfd_pkg::ST_BAD_VERSION;
                            res.frame_end    = 1'b1;
                        end else begin
                            phase_next = PH_KIND;
                        end
                    end
                end
                PH_KIND: begin
                    idx_next = 2'd0;
                    if (b > cfd_pkg::KIND_MAX) begin
                        phase_next       = PH_HALT;
                        res_valid        = 1'b1;
                        res.frame_status = cfd_pkg::ST_BAD_KIND;
                        res.frame_end    = 1'b1;
                    end else begin
                        kind_next  = b[3:0];
                        phase_next = PH_LENGTH;
                        shift_next = 32'd0;
                    end
                end
                PH_LENGTH: begin
                    shift_next = len_full;
                    idx_next   = cur_idx + 2'd1;
                    if (cur_idx == 2'd3) begin
                        idx_next = 2'd0;
                        if (len_over) begin
                            phase_next       = PH_HALT;
                            res_valid        = 1'b1;
                            res.frame_kind   = cur_kind;
                            res.frame_status = cfd_pkg::ST_TOO_LONG;
                            res.frame_end    = 1'b1;
                        end else begin
                            remain_next = len_full[LEN_WIDTH-1:0];
                            crc_next    = cfd_pkg::CRC_INIT;
                            rx_crc_next = 32'd0;
                            phase_next  = (len_full == 32'd0) ? PH_CRC : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    crc_next    = crc_upd;
                    remain_next = remain_dec;
                    if (remain_dec == '0) begin
                        phase_next  = PH_CRC;
                        idx_next    = 2'd0;
                        rx_crc_next = 32'd0;
                    end
                    res_valid        = 1'b1;
                    res.payload_byte = b;
                    res.is_payload   = 1'b1;
                    res.frame_kind   = cur_kind;
                end
                PH_CRC: begin
                    rx_crc_next = rx_full;
                    idx_next    = cur_idx + 2'd1;
                    if (cur_idx == 2'd3) begin
                        res_valid        = 1'b1;
                        res.frame_kind   = cur_kind;
                        res.frame_status = ((~cur_crc) == rx_full) ? cfd_pkg::ST_OK
                                                                  : cfd_pkg::ST_CRC_ERR;
                        res.frame_end    = 1'b1;
                        // back to hunting for the next header
                        phase_next  = PH_MAGIC;
                        idx_next    = 2'd0;
                        shift_next  = 32'd0;
                        ver_next    = 16'd0;
                        rx_crc_next = 32'd0;
                        crc_next    = cfd_pkg::CRC_INIT;
                        kind_next   = 4'd0;
                    end
                end
                default: begin
                    phase_next  = PH_MAGIC;
                    idx_next    = 2'd0;
                    shift_next  = 32'd0;
                    ver_next    = 16'd0;
                    rx_crc_next = 32'd0;
                    crc_next    = cfd_pkg::CRC_INIT;
                    kind_next   = 4'd0;
                end
            endcase
        end
    end

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_MAGIC;
            idx_reg    <= 2'd0;
            shift_reg  <= 32'd0;
            remain_reg <= '0;
            crc_reg    <= cfd_pkg::CRC_INIT;
            rx_crc_reg <= 32'd0;
            kind_reg   <= 4'd0;
            ver_reg    <= 16'd0;
        end else begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            shift_reg  <= shift_next;
            remain_reg <= remain_next;
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
            kind_reg   <= kind_next;
            ver_reg    <= ver_next;
        end
    end

    // Checks on the parser
    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (remain_reg != '0))
        else $error("payload phase with nothing left to pass");

    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HALT) |-> !res_valid)
        else $error("result produced while halted");

    a_header_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.frame_end && (res.frame_status != cfd_pkg::ST_OK) &&
         (res.frame_status != cfd_pkg::ST_CRC_ERR)) |=> (phase_reg == PH_HALT))
        else $error("header error did not halt the parser");

    a_crc_verdict_rehunts: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && (phase_reg == PH_CRC) && res_valid)
        |=> (phase_reg == PH_MAGIC) && (crc_reg == cfd_pkg::CRC_INIT))
        else $error("parser did not restart hunting after the CRC verdict");

endmodule

### src/crc_frame_deframer.sv
// Top level of the frame deframer: configuration registers, parser and result register.
// Depends on cfd_pkg and cfd_parser.
//
// Takes one stream byte per word on s_ and hands out at most one result word per byte
// on m_: each payload byte is passed through as it arrives, and a verdict word
// (frame_end set) follows the last CRC byte or any failed header check. The whole parse
// step, including the bytewise CRC-32 update, sits between the parser state and the
// result register, so a byte can be accepted in every cycle that s_ready is high and
// its result appears on m_ in the next cycle. s_ready is high whenever the result
// register is empty or is being taken in the same cycle. After a header error the block
// consumes bytes silently until one arrives with clear_error set. The user must write
// configuration via cfg_wr_en/cfg_addr/cfg_wdata while idle; the block does not check.
module crc_frame_deframer #(
    parameter int LEN_WIDTH = cfd_pkg::LEN_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // byte stream in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  cfd_pkg::in_word_t               s_word,
    // results out
    output logic                            m_valid,
    input  logic                            m_ready,
    output cfd_pkg::out_word_t              m_word,
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [cfd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    cfd_pkg::cfg_t       cfg_reg;
    logic                m_valid_reg;
    cfd_pkg::out_word_t  m_word_reg;
    logic                s_accept;
    logic                res_valid;
    cfd_pkg::out_word_t  res;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.magic   <= cfd_pkg::MAGIC_RESET;
            cfg_reg.version <= cfd_pkg::VERSION_RESET;
            cfg_reg.max_len <= cfd_pkg::MAX_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                cfd_pkg::REG_MAGIC:   cfg_reg.magic   <= cfg_wdata;
                cfd_pkg::REG_VERSION: cfg_reg.version <= cfg_wdata[15:0];
                cfd_pkg::REG_MAX_LEN: cfg_reg.max_len <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input handshake: take a byte when the result slot is free or draining
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    cfd_parser #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_word   (s_word),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            m_word_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

### bench/crc_frame_deframer_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for crc_frame_deframer: directed frames, then random traffic.
// Depends on cfd_pkg and the crc_frame_deframer RTL; results come from an in-bench deframer.
module crc_frame_deframer_test;
    import cfd_pkg::*;

    // Unused register slot, writes to it must have no effect
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PRINT_CAP = 50;

    typedef enum logic [2:0] {
        HUNT_MAGIC, GET_VERSION, GET_KIND, GET_LENGTH, IN_PAYLOAD, GET_CRC, HALTED
    } parse_phase_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_word;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_word;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Bench-side copy of the registers
    logic [31:0] cfg_magic;
    logic [15:0] cfg_version;
    logic [31:0] cfg_max_len;

    // Bench-side parser state
    parse_phase_t ph;
    logic [3:0]   fld_idx;
    logic [31:0]  word_acc;
    logic [31:0]  pay_left;
    logic [31:0]  crc_run;
    logic [31:0]  crc_rx;
    logic [3:0]   kind_held;
    logic [15:0]  ver_acc;

    out_word_t results_due[$];
    int        fail_count = 0;
    int        cycle_count = 0;
    int        bytes_counted = 0;
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        hold_len = 0;
    int        hold_req = 0;
    int        stray_clr_pct = 10;

    crc_frame_deframer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Reflected CRC-32, one data bit per step
    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] d);
        for (int k = 0; k < 8; k++) begin
            if (c[0] ^ d[k])
                c = {1'b0, c[31:1]} ^ CRC_POLY;
            else
                c = {1'b0, c[31:1]};
        end
        return c;
    endfunction

    function automatic void restart_hunt();
        ph        = HUNT_MAGIC;
        fld_idx   = '0;
        word_acc  = '0;
        ver_acc   = '0;
        crc_rx    = '0;
        crc_run   = CRC_INIT;
        kind_held = '0;
    endfunction

    function automatic void deframer_reset();
        cfg_magic   = MAGIC_RESET;
        cfg_version = VERSION_RESET;
        cfg_max_len = MAX_LEN_RESET;
        pay_left    = '0;
        restart_hunt();
    endfunction

    // Advance the bench parser by one byte; queue the result word it yields, if any
    task automatic deframe_step(input logic [7:0] b, input logic clr);
        out_word_t  r;
        logic       emitted;
        logic       hdr_fail;
        logic [4:0] sh;
        r        = '0;
        emitted  = 1'b0;
        hdr_fail = 1'b0;
        sh       = {fld_idx[1:0], 3'b000};
        case (ph)
            HALTED: begin
                if (clr) restart_hunt();
            end
            HUNT_MAGIC: begin
                word_acc |= {24'd0, b} << sh;
                fld_idx++;
                if (fld_idx >= 4) begin
                    if (word_acc != cfg_magic) begin
                        r.frame_status = ST_BAD_MAGIC;
                        hdr_fail = 1'b1;
                    end else begin
                        ph      = GET_VERSION;
                        fld_idx = '0;
                        ver_acc = '0;
                    end
                end
            end
            GET_VERSION: begin
                ver_acc |= {8'd0, b} << {fld_idx[0], 3'b000};
                fld_idx++;
                if (fld_idx >= 2) begin
                    if (ver_acc != cfg_version) begin
                        r.frame_status = ST_BAD_VERSION;
                        hdr_fail = 1'b1;
                    end else begin
                        ph      = GET_KIND;
                        fld_idx = '0;
                    end
                end
            end
            GET_KIND: begin
                if (b > KIND_MAX) begin
                    r.frame_status = ST_BAD_KIND;
                    hdr_fail = 1'b1;
                end else begin
                    kind_held = b[3:0];
                    ph        = GET_LENGTH;
                    fld_idx   = '0;
                    word_acc  = '0;
                end
            end
            GET_LENGTH: begin
                word_acc |= {24'd0, b} << sh;
                fld_idx++;
                if (fld_idx >= 4) begin
                    // with a 32-bit length field only the register limit applies
                    if (word_acc > cfg_max_len) begin
                        r.frame_kind   = kind_held;
                        r.frame_status = ST_TOO_LONG;
                        hdr_fail = 1'b1;
                    end else begin
                        pay_left = word_acc;
                        crc_run  = CRC_INIT;
                        crc_rx   = '0;
                        fld_idx  = '0;
                        ph       = (word_acc == 0) ? GET_CRC : IN_PAYLOAD;
                    end
                end
            end
            IN_PAYLOAD: begin
                crc_run = crc_update(crc_run, b);
                if (pay_left != 0) pay_left--;
                if (pay_left == 0) begin
                    ph      = GET_CRC;
                    fld_idx = '0;
                    crc_rx  = '0;
                end
                r.payload_byte = b;
                r.is_payload   = 1'b1;
                r.frame_kind   = kind_held;
                emitted = 1'b1;
            end
            GET_CRC: begin
                crc_rx |= {24'd0, b} << sh;
                fld_idx++;
                if (fld_idx >= 4) begin
                    r.frame_kind   = kind_held;
                    r.frame_status = (~crc_run == crc_rx) ? ST_OK : ST_CRC_ERR;
                    r.frame_end    = 1'b1;
                    emitted = 1'b1;
                    restart_hunt();
                end
            end
            default: restart_hunt();
        endcase
        // header failure: verdict, then halt until a clearing byte
        if (hdr_fail) begin
            r.frame_end = 1'b1;
            ph      = HALTED;
            fld_idx = '0;
            emitted = 1'b1;
        end
        if (emitted) results_due = {results_due, r};
    endtask

    // Offer one word on s_, wait for the handshake, then predict
    task automatic push_word(input logic [7:0] b, input logic clr);
        in_word_t w;
        w.rx_byte     = b;
        w.clear_error = clr;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (ph != HALTED || clr) bytes_counted++;
        deframe_step(b, clr);
    endtask

    // Clear flag on bytes that are not halted: ignored by the block
    function automatic logic stray_clear();
        return (ph != HALTED) && ($urandom_range(99) < stray_clr_pct);
    endfunction

    // Steer the parser back to the first magic byte by forcing a header failure, or by finishing the frame
    task automatic resync();
        while (!(ph == HUNT_MAGIC && fld_idx == 0)) begin
            case (ph)
                HALTED:      push_word(8'($urandom), 1'b1);
                HUNT_MAGIC:  push_word(~cfg_magic[8*fld_idx[1:0] +: 8], stray_clear());
                GET_VERSION: push_word(~cfg_version[8*fld_idx[0] +: 8], stray_clear());
                GET_KIND:    push_word(8'hFF, stray_clear());
                GET_LENGTH:  push_word(8'hFF, stray_clear());
                default:     push_word(8'($urandom), stray_clear());
            endcase
        end
    endtask

    // Send one frame; stops at a header failure, adds junk, then clears
    task automatic send_frame(input logic [31:0] magic, input logic [15:0] ver,
                              input logic [7:0] kind, input logic [31:0] len,
                              input int n_pay, input logic bad_crc);
        logic [7:0]  stream_q[$];
        logic [31:0] crc;
        logic [7:0]  b;
        crc = CRC_INIT;
        for (int i = 0; i < 4; i++) stream_q = {stream_q, magic[8*i +: 8]};
        for (int i = 0; i < 2; i++) stream_q = {stream_q, ver[8*i +: 8]};
        stream_q = {stream_q, kind};
        for (int i = 0; i < 4; i++) stream_q = {stream_q, len[8*i +: 8]};
        for (int i = 0; i < n_pay; i++) begin
            b = 8'($urandom);
            crc = crc_update(crc, b);
            stream_q = {stream_q, b};
        end
        crc = ~crc;
        if (bad_crc) crc ^= 32'd1 << $urandom_range(31);
        for (int i = 0; i < 4; i++) stream_q = {stream_q, crc[8*i +: 8]};
        foreach (stream_q[i]) begin
            if (ph == HALTED) break;
            push_word(stream_q[i], stray_clear());
        end
        if (ph == HALTED) repeat ($urandom_range(3)) push_word(8'($urandom), 1'b0);
        resync();
    endtask

    // Stop offering and let every due result come out
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MAGIC:   cfg_magic   = val;
            REG_VERSION: cfg_version = val[15:0];
            REG_MAX_LEN: cfg_max_len = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] magic, input logic [15:0] ver,
                             input logic [31:0] max_len);
        wait_for_results();
        write_reg(REG_MAGIC, magic);
        write_reg(REG_VERSION, {16'd0, ver});
        write_reg(REG_MAX_LEN, max_len);
    endtask

    // One random frame: mostly well formed, some broken, some noise
    task automatic random_frame();
        int          pick;
        int          n;
        logic [7:0]  kind;
        logic [31:0] len;
        pick = $urandom_range(99);
        kind = 8'($urandom_range(13));
        n    = ($urandom_range(15) == 0) ? $urandom_range(64) : $urandom_range(10);
        if (n > cfg_max_len) n = int'(cfg_max_len);
        if (pick < 55)
            send_frame(cfg_magic, cfg_version, kind, 32'(n), n, 1'b0);
        else if (pick < 65)
            send_frame(cfg_magic, cfg_version, kind, 32'(n), n, 1'b1);
        else if (pick < 71)
            send_frame(cfg_magic ^ (32'($urandom) | (32'd1 << $urandom_range(31))),
                       cfg_version, kind, 32'(n), n, 1'b0);
        else if (pick < 77)
            send_frame(cfg_magic, cfg_version ^ (16'($urandom) | (16'd1 << $urandom_range(15))),
                       kind, 32'(n), n, 1'b0);
        else if (pick < 83)
            send_frame(cfg_magic, cfg_version, 8'($urandom_range(255, 14)), 32'(n), n, 1'b0);
        else if (pick < 89 && cfg_max_len < 32'hFF00_0000) begin
            len = cfg_max_len + 32'd1 + ($urandom_range(1) ? 32'd0 : {8'd0, 24'($urandom)});
            send_frame(cfg_magic, cfg_version, kind, len, n, 1'b0);
        end else begin
            repeat ($urandom_range(6, 1)) push_word(8'($urandom), 1'($urandom_range(1)));
            resync();
        end
    endtask

    // Reset register values: zero magic and version, 64 KiB limit
    task automatic test_reset_defaults();
        send_frame(32'd0, 16'd0, 8'd0, 32'd0, 0, 1'b0);
        send_frame(32'd0, 16'd0, 8'd13, 32'd1, 1, 1'b0);
    endtask

    // Each header check, halting with ignored bytes, and clear outside halt
    task automatic test_header_checks();
        configure(32'hFFFF_FFFF, 16'hFFFF, MAX_LEN_RESET);
        stray_clr_pct = 100;
        send_frame(cfg_magic, cfg_version, 8'd13, 32'd2, 2, 1'b0);
        stray_clr_pct = 10;
        send_frame(32'h7FFF_FFFF, cfg_version, 8'd0, 32'd0, 0, 1'b0);
        send_frame(cfg_magic, 16'hFFFE, 8'd0, 32'd0, 0, 1'b0);
        send_frame(cfg_magic, cfg_version, 8'd14, 32'd0, 0, 1'b0);
        send_frame(cfg_magic, cfg_version, 8'd255, 32'd0, 0, 1'b0);
        send_frame(cfg_magic, cfg_version, 8'd13, 32'd65537, 0, 1'b0);
        send_frame(cfg_magic, cfg_version, 8'd7, 32'hFFFF_FFFF, 0, 1'b0);
    endtask

    // Length limit at both extremes; the spare register index does nothing
    task automatic test_length_extremes();
        configure(32'h0000_0001, 16'h8000, 32'd0);
        send_frame(cfg_magic, cfg_version, 8'd5, 32'd0, 0, 1'b0);
        send_frame(cfg_magic, cfg_version, 8'd9, 32'd1, 1, 1'b0);
        configure(32'hA5C3_0F96, 16'h1234, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, 32'($urandom));
        send_frame(cfg_magic, cfg_version, 8'd3, 32'd5, 5, 1'b0);
    endtask

    // A CRC mismatch does not halt: the next frame parses straight away
    task automatic test_crc_mismatch();
        send_frame(cfg_magic, cfg_version, 8'd11, 32'd3, 3, 1'b1);
        send_frame(cfg_magic, cfg_version, 8'd12, 32'd0, 0, 1'b1);
        send_frame(cfg_magic, cfg_version, 8'd1, 32'd4, 4, 1'b0);
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_output_stall();
        configure(32'($urandom), 16'($urandom), 32'd64);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_len       = 400;
        hold_req++;
        repeat (4) send_frame(cfg_magic, cfg_version, 8'($urandom_range(13)), 32'd8, 8, 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int quota);
        int start_cnt;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start_cnt      = bytes_counted;
        while (bytes_counted - start_cnt < quota) begin
            random_frame();
            // occasional pause until the block has drained
            if ($urandom_range(39) == 0) wait_for_results();
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when requested
    initial begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= PRINT_CAP)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Result checker: each word against the oldest due result
    always @(posedge aclk) begin : result_check
        out_word_t due;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= PRINT_CAP)
                    $display("%0t: unexpected word, expected none actual %h", $time, m_word);
            end else begin
                due = results_due.pop_front();
                check_field("payload_byte", due.payload_byte, m_word.payload_byte);
                check_field("is_payload", 8'(due.is_payload), 8'(m_word.is_payload));
                check_field("frame_kind", 8'(due.frame_kind), 8'(m_word.frame_kind));
                check_field("frame_status", 8'(due.frame_status), 8'(m_word.frame_status));
                check_field("frame_end", 8'(due.frame_end), 8'(m_word.frame_end));
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("crc_frame_deframer verification failed");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_word    = '0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        deframer_reset();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_header_checks();
        test_length_extremes();
        test_crc_mismatch();
        test_output_stall();

        configure(32'($urandom), 16'($urandom), MAX_LEN_RESET);
        test_random_traffic(0, 0, 400);
        configure(32'($urandom), 16'($urandom), 32'($urandom_range(24, 1)));
        test_random_traffic(85, 0, 400);
        configure(32'd0, 16'd0, 32'($urandom_range(8)));
        test_random_traffic(0, 85, 400);
        configure(32'hFFFF_FFFF, 16'hFFFF, MAX_LEN_RESET);
        test_random_traffic(36, 36, 400);

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("crc_frame_deframer verification clean");
        else
            $display("crc_frame_deframer verification failed");
        $finish;
    end

endmodule

### sim.f
src/cfd_pkg.sv
src/cfd_parser.sv
src/crc_frame_deframer.sv
bench/crc_frame_deframer_test.sv
